// ----- rtl/core/process_pool_list_engine_macros.svh -----
// assertion macros for the process pool list engine checker
// used by ppl_checker only; needs clk and rst in the including scope
`ifndef PROCESS_POOL_LIST_ENGINE_MACROS_SVH
`define PROCESS_POOL_LIST_ENGINE_MACROS_SVH

// checked only outside reset
`define PPL_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

// checked during reset as well
`define PPL_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) expr) else $error(msg);

`endif

// ----- rtl/core/ppl_pkg.sv -----
// shared types and constants of the process pool list engine
// no dependencies; imported by every module of the block
package ppl_pkg;

  localparam int POOL_SIZE_DEF   = 32;
  localparam int QUEUE_COUNT_DEF = 16;

  // sized for the largest pool and queue count the block supports
  localparam int IX_W  = 9;
  localparam int TAG_W = 7;
  localparam int QX_W  = 6;

  typedef logic [IX_W-1:0]  ix_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [QX_W-1:0]  qx_t;

  typedef enum logic [3:0] {
    OP_ALLOC   = 4'd0,
    OP_FREE    = 4'd1,
    OP_QINSERT = 4'd2,
    OP_QHEAD   = 4'd3,
    OP_QREMOVE = 4'd4,
    OP_QOUT    = 4'd5,
    OP_QEMPTY  = 4'd6,
    OP_CINSERT = 4'd7,
    OP_CREMOVE = 4'd8,
    OP_COUT    = 4'd9,
    OP_CEMPTY  = 4'd10
  } op_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_REFUSE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WR
  } state_t;

  typedef struct packed {
    ix_t  nxt;
    ix_t  prv;
    tag_t tag;
    ix_t  cf;
    ix_t  cl;
    ix_t  sn;
    ix_t  sp;
    ix_t  par;
  } rec_t;

  typedef struct packed {
    logic nxt;
    logic prv;
    logic tag;
    logic cf;
    logic cl;
    logic sn;
    logic sp;
    logic par;
  } rmask_t;

  typedef struct packed {
    logic   en;
    ix_t    addr;
    rmask_t mask;
    rec_t   data;
  } rwr_t;

  typedef struct packed {
    ix_t first;
    ix_t last;
  } qrec_t;

  typedef struct packed {
    logic  en;
    qx_t   addr;
    logic  m_first;
    logic  m_last;
    qrec_t data;
  } qwr_t;

endpackage

// ----- rtl/core/ppl_ent_mem.sv -----
// per-entry record memory: list links, membership tag, child list links
// depends on ppl_pkg; one read port with registered data, one masked write port
module ppl_ent_mem
  import ppl_pkg::*;
#(
  parameter int POOL_SIZE   = POOL_SIZE_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic rd_en,
  input  ix_t  rd_addr,
  output rec_t rd_data,
  input  rwr_t wr
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  rec_t             mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] vld;
  rec_t             raw;
  logic             rvld;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    wa;
  rec_t             wd;
  rec_t             wini;
  rmask_t           em;

  function automatic rec_t rec_init(input logic [AW-1:0] i);
    rec_t r;
    r.nxt = (i == '0) ? ix_t'(POOL_SIZE) : ix_t'(i) - ix_t'(1);
    r.prv = ix_t'(i) + ix_t'(1);
    r.tag = tag_t'(QUEUE_COUNT);
    r.cf  = ix_t'(POOL_SIZE);
    r.cl  = ix_t'(POOL_SIZE);
    r.sn  = ix_t'(POOL_SIZE);
    r.sp  = ix_t'(POOL_SIZE);
    r.par = ix_t'(POOL_SIZE);
    return r;
  endfunction

  assign wa   = wr.addr[AW-1:0];
  assign wini = rec_init(wa);

  // an entry never written takes its reset value in the fields not written
  always_comb begin
    em     = wr.mask | {$bits(rmask_t){~vld[wa]}};
    wd.nxt = wr.mask.nxt ? wr.data.nxt : wini.nxt;
    wd.prv = wr.mask.prv ? wr.data.prv : wini.prv;
    wd.tag = wr.mask.tag ? wr.data.tag : wini.tag;
    wd.cf  = wr.mask.cf  ? wr.data.cf  : wini.cf;
    wd.cl  = wr.mask.cl  ? wr.data.cl  : wini.cl;
    wd.sn  = wr.mask.sn  ? wr.data.sn  : wini.sn;
    wd.sp  = wr.mask.sp  ? wr.data.sp  : wini.sp;
    wd.par = wr.mask.par ? wr.data.par : wini.par;
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (em.nxt) mem[wa].nxt <= wd.nxt;
      if (em.prv) mem[wa].prv <= wd.prv;
      if (em.tag) mem[wa].tag <= wd.tag;
      if (em.cf)  mem[wa].cf  <= wd.cf;
      if (em.cl)  mem[wa].cl  <= wd.cl;
      if (em.sn)  mem[wa].sn  <= wd.sn;
      if (em.sp)  mem[wa].sp  <= wd.sp;
      if (em.par) mem[wa].par <= wd.par;
    end
    if (rd_en) begin
      raw   <= mem[rd_addr[AW-1:0]];
      rvld  <= vld[rd_addr[AW-1:0]];
      raddr <= rd_addr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wa] <= 1'b1;
    end
  end

  assign rd_data = rvld ? raw : rec_init(raddr);

endmodule

// ----- rtl/core/ppl_q_mem.sv -----
// process queue head and tail memory
// depends on ppl_pkg; one read port with registered data, one masked write port
module ppl_q_mem
  import ppl_pkg::*;
#(
  parameter int POOL_SIZE   = POOL_SIZE_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  rd_en,
  input  qx_t   rd_addr,
  output qrec_t rd_data,
  input  qwr_t  wr
);

  localparam int QA = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  qrec_t                  mem [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] vld;
  qrec_t                  raw;
  logic                   rvld;
  logic [QA-1:0]          wa;

  assign wa = wr.addr[QA-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.m_first || !vld[wa]) begin
        mem[wa].first <= wr.m_first ? wr.data.first : ix_t'(POOL_SIZE);
      end
      if (wr.m_last || !vld[wa]) begin
        mem[wa].last <= wr.m_last ? wr.data.last : ix_t'(POOL_SIZE);
      end
    end
    if (rd_en) begin
      raw  <= mem[rd_addr[QA-1:0]];
      rvld <= vld[rd_addr[QA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wa] <= 1'b1;
    end
  end

  assign rd_data = rvld ? raw : qrec_t'{first: ix_t'(POOL_SIZE), last: ix_t'(POOL_SIZE)};

endmodule

// ----- rtl/core/ppl_ctrl.sv -----
// operation sequencer: reads records, plans up to three masked writes, commits
// depends on ppl_pkg; drives ppl_ent_mem and ppl_q_mem, owns free stack top
module ppl_ctrl
  import ppl_pkg::*;
#(
  parameter int POOL_SIZE   = POOL_SIZE_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [3:0]  op,
  input  logic [4:0]  entry,
  input  logic [4:0]  parent,
  input  logic [3:0]  queue,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [4:0]  result_entry,
  output logic        is_empty,
  output logic        ent_rd_en,
  output ix_t         ent_rd_addr,
  input  rec_t        ent_rd_data,
  output rwr_t        ent_wr,
  output logic        q_rd_en,
  output qx_t         q_rd_addr,
  input  qrec_t       q_rd_data,
  output qwr_t        q_wr
);

  localparam ix_t  NONE     = ix_t'(POOL_SIZE);
  localparam tag_t TAG_FREE = tag_t'(QUEUE_COUNT);
  localparam tag_t TAG_IDLE = tag_t'(QUEUE_COUNT + 1);

  state_t     state, state_next;
  ix_t        ft;
  logic [3:0] op_r;
  ix_t        e_r;
  ix_t        par_r;
  logic [3:0] q_r;
  rec_t       ra;
  rwr_t       w_q [3];
  qwr_t       qw_q;
  ix_t        ft_q;
  logic [1:0] st_q;
  ix_t        res_q;
  logic       emp_q;
  logic [1:0] last_q;
  logic [1:0] k;

  rwr_t       p_w [3];
  qwr_t       p_qw;
  ix_t        p_ft;
  logic [1:0] p_st;
  ix_t        p_res;
  logic       p_emp;
  logic [1:0] p_last;

  logic       accept;
  logic       finish;
  logic       e_ok, q_ok, par_ok;
  rec_t       rb;
  qrec_t      qa;
  ix_t        un_n, un_p, un_pa;

  function automatic logic is_none(input ix_t x);
    return x >= NONE;
  endfunction

  assign accept    = req_valid && (state == S_IDLE);
  assign req_stall = (state != S_IDLE);
  assign finish    = (state == S_WR) && (k == last_q) && (!rsp_valid || !rsp_stall);

  assign ent_rd_en   = accept || (state == S_RD1);
  assign q_rd_en     = accept;
  assign q_rd_addr   = qx_t'(queue);
  assign rb          = ent_rd_data;
  assign qa          = q_rd_data;

  always_comb begin
    ent_rd_addr = ix_t'(entry);
    if (state == S_IDLE) begin
      ent_rd_addr = (op == OP_ALLOC) ? ft : ix_t'(entry);
    end else begin
      case (op_r)
        OP_CINSERT: ent_rd_addr = par_r;
        OP_CREMOVE: ent_rd_addr = ent_rd_data.cf;
        OP_QREMOVE: ent_rd_addr = q_rd_data.first;
        default:    ent_rd_addr = e_r;
      endcase
    end
  end

  assign e_ok   = e_r < NONE;
  assign par_ok = par_r < NONE;
  assign q_ok   = {2'b0, q_r} < QX_W'(QUEUE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_WR;
      S_WR:    if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // write plan for the item, built from the record reads
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_w[i] = '0;
    end
    p_qw  = '0;
    p_qw.addr = qx_t'(q_r);
    p_ft  = ft;
    p_st  = ST_REFUSE;
    p_res = '0;
    p_emp = 1'b0;
    un_n  = NONE;
    un_p  = NONE;
    un_pa = NONE;
    case (op_r)
      OP_ALLOC: begin
        if (is_none(ft)) begin
          p_st = ST_MISS;
        end else begin
          p_st  = ST_DONE;
          p_res = ft;
          p_ft  = ra.nxt;
          p_w[0].en   = 1'b1;
          p_w[0].addr = ft;
          p_w[0].mask = '1;
          p_w[0].data = '{nxt: NONE, prv: NONE, tag: TAG_IDLE, cf: NONE, cl: NONE,
                          sn: NONE, sp: NONE, par: NONE};
          if (!is_none(ra.nxt)) begin
            p_w[1].en       = 1'b1;
            p_w[1].addr     = ra.nxt;
            p_w[1].mask.prv = 1'b1;
            p_w[1].data.prv = NONE;
          end
        end
      end
      OP_FREE: begin
        if (e_ok) begin
          if (ra.tag == TAG_FREE) begin
            p_st  = ST_DONE;
            p_res = e_r;
          end else if (ra.tag == TAG_IDLE && is_none(ra.par) && is_none(ra.cf)) begin
            p_st  = ST_DONE;
            p_res = e_r;
            p_ft  = e_r;
            p_w[0].en       = 1'b1;
            p_w[0].addr     = e_r;
            p_w[0].mask.nxt = 1'b1;
            p_w[0].mask.prv = 1'b1;
            p_w[0].mask.tag = 1'b1;
            p_w[0].data.nxt = ft;
            p_w[0].data.prv = NONE;
            p_w[0].data.tag = TAG_FREE;
            if (!is_none(ft)) begin
              p_w[1].en       = 1'b1;
              p_w[1].addr     = ft;
              p_w[1].mask.prv = 1'b1;
              p_w[1].data.prv = e_r;
            end
          end
        end
      end
      OP_QINSERT: begin
        if (e_ok && q_ok && ra.tag == TAG_IDLE) begin
          p_st  = ST_DONE;
          p_res = e_r;
          p_w[0].en       = 1'b1;
          p_w[0].addr     = e_r;
          p_w[0].mask.nxt = 1'b1;
          p_w[0].mask.prv = 1'b1;
          p_w[0].mask.tag = 1'b1;
          p_w[0].data.nxt = NONE;
          p_w[0].data.prv = qa.last;
          p_w[0].data.tag = tag_t'(q_r);
          p_qw.en         = 1'b1;
          p_qw.m_last     = 1'b1;
          p_qw.data.last  = e_r;
          p_qw.data.first = e_r;
          if (!is_none(qa.last)) begin
            p_w[1].en       = 1'b1;
            p_w[1].addr     = qa.last;
            p_w[1].mask.nxt = 1'b1;
            p_w[1].data.nxt = e_r;
          end else begin
            p_qw.m_first = 1'b1;
          end
        end
      end
      OP_QHEAD, OP_QREMOVE, OP_QOUT: begin
        if (op_r == OP_QOUT) begin
          if (e_ok && q_ok) begin
            if (ra.tag != tag_t'(q_r)) begin
              p_st = ST_MISS;
            end else begin
              p_st  = ST_DONE;
              p_res = e_r;
              un_n  = ra.nxt;
              un_p  = ra.prv;
            end
          end
        end else if (q_ok) begin
          if (is_none(qa.first)) begin
            p_st  = ST_MISS;
            p_emp = 1'b1;
          end else begin
            p_st  = ST_DONE;
            p_res = qa.first;
            un_n  = rb.nxt;
            un_p  = rb.prv;
          end
        end
        if (p_st == ST_DONE && op_r != OP_QHEAD) begin
          p_w[0].en       = 1'b1;
          p_w[0].addr     = p_res;
          p_w[0].mask.nxt = 1'b1;
          p_w[0].mask.prv = 1'b1;
          p_w[0].mask.tag = 1'b1;
          p_w[0].data.nxt = NONE;
          p_w[0].data.prv = NONE;
          p_w[0].data.tag = TAG_IDLE;
          p_qw.data.first = un_n;
          p_qw.data.last  = un_p;
          p_qw.m_first    = is_none(un_p);
          p_qw.m_last     = is_none(un_n);
          p_qw.en         = is_none(un_p) || is_none(un_n);
          if (!is_none(un_p)) begin
            p_w[1].en       = 1'b1;
            p_w[1].addr     = un_p;
            p_w[1].mask.nxt = 1'b1;
            p_w[1].data.nxt = un_n;
          end
          if (!is_none(un_n)) begin
            p_w[2].en       = 1'b1;
            p_w[2].addr     = un_n;
            p_w[2].mask.prv = 1'b1;
            p_w[2].data.prv = un_p;
          end
        end
      end
      OP_QEMPTY: begin
        if (q_ok) begin
          p_st  = ST_DONE;
          p_emp = is_none(qa.first);
        end
      end
      OP_CINSERT: begin
        if (e_ok && par_ok && e_r != par_r && ra.tag != TAG_FREE && rb.tag != TAG_FREE
            && is_none(ra.par)) begin
          p_st  = ST_DONE;
          p_res = e_r;
          p_w[0].en       = 1'b1;
          p_w[0].addr     = e_r;
          p_w[0].mask.sn  = 1'b1;
          p_w[0].mask.sp  = 1'b1;
          p_w[0].mask.par = 1'b1;
          p_w[0].data.sn  = NONE;
          p_w[0].data.sp  = rb.cl;
          p_w[0].data.par = par_r;
          if (!is_none(rb.cl)) begin
            p_w[1].en      = 1'b1;
            p_w[1].addr    = rb.cl;
            p_w[1].mask.sn = 1'b1;
            p_w[1].data.sn = e_r;
            p_w[2].en      = 1'b1;
            p_w[2].addr    = par_r;
            p_w[2].mask.cl = 1'b1;
            p_w[2].data.cl = e_r;
          end else begin
            p_w[1].en      = 1'b1;
            p_w[1].addr    = par_r;
            p_w[1].mask.cf = 1'b1;
            p_w[1].mask.cl = 1'b1;
            p_w[1].data.cf = e_r;
            p_w[1].data.cl = e_r;
          end
        end
      end
      OP_CREMOVE, OP_COUT: begin
        if (e_ok) begin
          if (op_r == OP_CREMOVE) begin
            if (is_none(ra.cf)) begin
              p_st  = ST_MISS;
              p_emp = 1'b1;
            end else begin
              p_st  = ST_DONE;
              p_res = ra.cf;
              un_n  = rb.sn;
              un_p  = rb.sp;
              un_pa = rb.par;
            end
          end else if (is_none(ra.par)) begin
            p_st = ST_MISS;
          end else begin
            p_st  = ST_DONE;
            p_res = e_r;
            un_n  = ra.sn;
            un_p  = ra.sp;
            un_pa = ra.par;
          end
        end
        if (p_st == ST_DONE && !is_none(un_pa)) begin
          p_w[0].en       = 1'b1;
          p_w[0].addr     = p_res;
          p_w[0].mask.sn  = 1'b1;
          p_w[0].mask.sp  = 1'b1;
          p_w[0].mask.par = 1'b1;
          p_w[0].data.sn  = NONE;
          p_w[0].data.sp  = NONE;
          p_w[0].data.par = NONE;
          p_w[1].en       = 1'b1;
          if (!is_none(un_p)) begin
            p_w[1].addr    = un_p;
            p_w[1].mask.sn = 1'b1;
            p_w[1].data.sn = un_n;
          end else begin
            p_w[1].addr    = un_pa;
            p_w[1].mask.cf = 1'b1;
            p_w[1].data.cf = un_n;
            p_w[1].mask.cl = is_none(un_n);
            p_w[1].data.cl = un_p;
          end
          if (!is_none(un_n)) begin
            p_w[2].en      = 1'b1;
            p_w[2].addr    = un_n;
            p_w[2].mask.sp = 1'b1;
            p_w[2].data.sp = un_p;
          end else if (!is_none(un_p)) begin
            p_w[2].en      = 1'b1;
            p_w[2].addr    = un_pa;
            p_w[2].mask.cl = 1'b1;
            p_w[2].data.cl = un_p;
          end
        end
      end
      OP_CEMPTY: begin
        if (e_ok) begin
          p_st  = ST_DONE;
          p_emp = is_none(ra.cf);
        end
      end
      default: begin
        p_st = ST_REFUSE;
      end
    endcase
    if (p_st != ST_DONE) begin
      p_res = '0;
    end
    p_last = p_w[2].en ? 2'd2 : (p_w[1].en ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op;
      e_r   <= ix_t'(entry);
      par_r <= ix_t'(parent);
      q_r   <= queue;
    end
    if (state == S_RD1) begin
      ra <= ent_rd_data;
    end
    if (state == S_RD2) begin
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= p_w[i];
      end
      qw_q   <= p_qw;
      ft_q   <= p_ft;
      st_q   <= p_st;
      res_q  <= p_res;
      emp_q  <= p_emp;
      last_q <= p_last;
    end
    if (finish) begin
      status       <= st_q;
      result_entry <= res_q[4:0];
      is_empty     <= emp_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ft        <= ix_t'(POOL_SIZE - 1);
      k         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_WR && k == 2'd0) begin
        ft <= ft_q;
      end
      if (state == S_RD2) begin
        k <= '0;
      end else if (state == S_WR && k != last_q) begin
        k <= k + 2'd1;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    ent_wr = '0;
    q_wr   = '0;
    if (state == S_WR) begin
      ent_wr = w_q[k];
      if (k == 2'd0) begin
        q_wr = qw_q;
      end
    end
  end

endmodule

// ----- rtl/core/process_pool_list_engine.sv -----
// channel | beat contents                          | handshake
// request | op, entry, parent, queue               | req_valid / req_stall
// result  | status, result_entry, is_empty         | rsp_valid / rsp_stall
//
// one request at a time: accept, two record reads, then up to three writes
// (one per linked record touched) through the entry memory port
// req_stall stays high from acceptance until the result is in the output register
// a stalled result holds the sequencer in its last write cycle
// reset is synchronous; memory contents need no clearing pass, per-entry valid bits
// give the reset links
module process_pool_list_engine
  import ppl_pkg::*;
#(
  parameter int POOL_SIZE   = POOL_SIZE_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [3:0] op,
  input  logic [4:0] entry,
  input  logic [4:0] parent,
  input  logic [3:0] queue,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [1:0] status,
  output logic [4:0] result_entry,
  output logic       is_empty
);

  logic  ent_rd_en;
  ix_t   ent_rd_addr;
  rec_t  ent_rd_data;
  rwr_t  ent_wr;
  logic  q_rd_en;
  qx_t   q_rd_addr;
  qrec_t q_rd_data;
  qwr_t  q_wr;

  ppl_ctrl #(
    .POOL_SIZE   (POOL_SIZE),
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .op           (op),
    .entry        (entry),
    .parent       (parent),
    .queue        (queue),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .result_entry (result_entry),
    .is_empty     (is_empty),
    .ent_rd_en    (ent_rd_en),
    .ent_rd_addr  (ent_rd_addr),
    .ent_rd_data  (ent_rd_data),
    .ent_wr       (ent_wr),
    .q_rd_en      (q_rd_en),
    .q_rd_addr    (q_rd_addr),
    .q_rd_data    (q_rd_data),
    .q_wr         (q_wr)
  );

  ppl_ent_mem #(
    .POOL_SIZE   (POOL_SIZE),
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_ent_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data),
    .wr      (ent_wr)
  );

  ppl_q_mem #(
    .POOL_SIZE   (POOL_SIZE),
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_q_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data),
    .wr      (q_wr)
  );

endmodule

// ----- rtl/core/ppl_checker.sv -----
// port-level checks of the process pool list engine, bound to the top level
// depends on ppl_pkg and process_pool_list_engine_macros.svh
`include "process_pool_list_engine_macros.svh"

module ppl_checker
  import ppl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic [3:0] op,
  input logic [4:0] entry,
  input logic [4:0] parent,
  input logic [3:0] queue,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [1:0] status,
  input logic [4:0] result_entry,
  input logic       is_empty
);

  `PPL_ASSERT(a_status_code, rsp_valid |-> status <= ST_REFUSE, "status code out of range")
  `PPL_ASSERT(a_res_zero, (rsp_valid && status != ST_DONE) |-> result_entry == 5'd0,
              "result not zero")
  `PPL_ASSERT(a_refuse_empty, (rsp_valid && status == ST_REFUSE) |-> !is_empty, "empty on refuse")
  `PPL_ASSERT(a_one_at_a_time, (req_valid && !req_stall) |=> req_stall, "second beat taken early")
  `PPL_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !rsp_valid, "result beat after reset")

endmodule

bind process_pool_list_engine ppl_checker u_ppl_checker (.*);

// ----- tb/process_pool_list_engine_tb.sv -----
// self-checking testbench for process_pool_list_engine: directed table, pool drain, then random ops
// predicts every result beat with a behavioral copy of the pool, queue and child lists
// depends on ppl_pkg and the process_pool_list_engine rtl
`timescale 1ns / 100ps

module process_pool_list_engine_tb;
  import ppl_pkg::*;

  localparam int NPOOL = 32;
  localparam int NQ = 16;
  localparam int NIL = NPOOL;
  localparam int TAG_FREE = NQ;
  localparam int TAG_IDLE = NQ + 1;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] result_entry;
    logic       is_empty;
  } rsp_t;

  typedef struct {
    logic [3:0] op;
    logic [4:0] entry;
    logic [4:0] parent;
    logic [3:0] queue;
    logic       known;
    rsp_t       rsp;
  } row_t;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall, is_empty;
  logic [3:0] op, queue;
  logic [4:0] entry, parent, result_entry;
  logic [1:0] status;

  process_pool_list_engine dut (.*);

  int free_top;
  int lnext[NPOOL], lprev[NPOOL], tag[NPOOL];
  int qfirst[NQ], qlast[NQ];
  int cfirst[NPOOL], clast[NPOOL], snext[NPOOL], sprev[NPOOL], par_of[NPOOL];

  rsp_t pending_rsp[$];
  rsp_t known_rsp[$];
  logic known_flag[$];
  int errors, n_rsp, n_req, cycles;
  int send_idle, recv_idle;
  bit hold_off;
  row_t dir[$];

  function automatic void pool_reset();
    free_top = NPOOL - 1;
    for (int i = 0; i < NPOOL; i++) begin
      lnext[i] = (i == 0) ? NIL : i - 1;
      lprev[i] = i + 1;
      tag[i] = TAG_FREE;
      cfirst[i] = NIL; clast[i] = NIL; snext[i] = NIL; sprev[i] = NIL; par_of[i] = NIL;
    end
    for (int i = 0; i < NQ; i++) begin
      qfirst[i] = NIL; qlast[i] = NIL;
    end
  endfunction

  function automatic void q_unlink(int q, int e);
    int n, p;
    n = lnext[e]; p = lprev[e];
    if (p < NPOOL) lnext[p] = n; else qfirst[q] = n;
    if (n < NPOOL) lprev[n] = p; else qlast[q] = p;
    lnext[e] = NIL; lprev[e] = NIL; tag[e] = TAG_IDLE;
  endfunction

  function automatic void c_unlink(int e);
    int pa, n, p;
    pa = par_of[e]; n = snext[e]; p = sprev[e];
    if (pa >= NPOOL) return;
    if (p < NPOOL) snext[p] = n; else cfirst[pa] = n;
    if (n < NPOOL) sprev[n] = p; else clast[pa] = p;
    snext[e] = NIL; sprev[e] = NIL; par_of[e] = NIL;
  endfunction

  function automatic rsp_t pool_step(logic [3:0] o, int e, int pa, int q);
    int st, res, emp;
    rsp_t r;
    st = ST_REFUSE; res = 0; emp = 0;
    case (o)
      OP_ALLOC: begin
        if (free_top >= NPOOL) st = ST_MISS;
        else begin
          res = free_top;
          free_top = lnext[res];
          if (free_top < NPOOL) lprev[free_top] = NIL;
          lnext[res] = NIL; lprev[res] = NIL; tag[res] = TAG_IDLE;
          par_of[res] = NIL; cfirst[res] = NIL; clast[res] = NIL;
          snext[res] = NIL; sprev[res] = NIL;
          st = ST_DONE;
        end
      end
      OP_FREE: begin
        if (tag[e] == TAG_FREE) begin
          st = ST_DONE; res = e;
        end else if (tag[e] == TAG_IDLE && par_of[e] >= NPOOL && cfirst[e] >= NPOOL) begin
          lnext[e] = free_top; lprev[e] = NIL;
          if (free_top < NPOOL) lprev[free_top] = e;
          free_top = e; tag[e] = TAG_FREE;
          st = ST_DONE; res = e;
        end
      end
      OP_QINSERT: begin
        if (tag[e] == TAG_IDLE) begin
          lnext[e] = NIL; lprev[e] = qlast[q];
          if (qlast[q] < NPOOL) lnext[qlast[q]] = e; else qfirst[q] = e;
          qlast[q] = e; tag[e] = q;
          st = ST_DONE; res = e;
        end
      end
      OP_QHEAD, OP_QREMOVE: begin
        if (qfirst[q] >= NPOOL) begin
          st = ST_MISS; emp = 1;
        end else begin
          res = qfirst[q];
          if (o == OP_QREMOVE) q_unlink(q, res);
          st = ST_DONE;
        end
      end
      OP_QOUT: begin
        if (tag[e] != q) st = ST_MISS;
        else begin
          q_unlink(q, e); st = ST_DONE; res = e;
        end
      end
      OP_QEMPTY: begin
        st = ST_DONE; emp = qfirst[q] >= NPOOL;
      end
      OP_CINSERT: begin
        if (e != pa && tag[e] != TAG_FREE && tag[pa] != TAG_FREE && par_of[e] >= NPOOL) begin
          snext[e] = NIL; sprev[e] = clast[pa];
          if (clast[pa] < NPOOL) snext[clast[pa]] = e; else cfirst[pa] = e;
          clast[pa] = e; par_of[e] = pa;
          st = ST_DONE; res = e;
        end
      end
      OP_CREMOVE: begin
        if (cfirst[e] >= NPOOL) begin
          st = ST_MISS; emp = 1;
        end else begin
          res = cfirst[e]; c_unlink(res); st = ST_DONE;
        end
      end
      OP_COUT: begin
        if (par_of[e] >= NPOOL) st = ST_MISS;
        else begin
          c_unlink(e); st = ST_DONE; res = e;
        end
      end
      OP_CEMPTY: begin
        st = ST_DONE; emp = cfirst[e] >= NPOOL;
      end
      default: ;
    endcase
    if (st != ST_DONE) res = 0;
    r.status = st[1:0];
    r.result_entry = res[4:0];
    r.is_empty = emp[0];
    return r;
  endfunction

  function automatic rsp_t mk(int st, int res, int emp);
    rsp_t r;
    r.status = st[1:0]; r.result_entry = res[4:0]; r.is_empty = emp[0];
    return r;
  endfunction

  function automatic void add_row(logic [3:0] o, int e, int pa, int q, bit k, rsp_t r);
    row_t w;
    w.op = o; w.entry = e[4:0]; w.parent = pa[4:0]; w.queue = q[3:0];
    w.known = k; w.rsp = r;
    dir.push_back(w);
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout at %0t", $time);
        $display("FAIL process_pool_list_engine");
        $finish;
      end
    end
  end

  // response side: stall driver and checker
  initial begin
    rsp_stall = 0;
    n_rsp = 0;
    errors = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected beat status=%0d entry=%0d empty=%0d", $time,
                   status, result_entry, is_empty);
          errors++;
        end else begin
          rsp_t x, k;
          logic kf;
          x = pending_rsp.pop_front();
          k = known_rsp.pop_front();
          kf = known_flag.pop_front();
          if (kf && k != x) begin
            $display("%0t table/predictor disagree exp=%h got=%h", $time, k, x);
            errors++;
          end
          if (status !== x.status) begin
            $display("%0t status exp=%0d act=%0d", $time, x.status, status);
            errors++;
          end
          if (result_entry !== x.result_entry) begin
            $display("%0t result_entry exp=%0d act=%0d", $time, x.result_entry, result_entry);
            errors++;
          end
          if (is_empty !== x.is_empty) begin
            $display("%0t is_empty exp=%0d act=%0d", $time, x.is_empty, is_empty);
            errors++;
          end
        end
        n_rsp++;
      end
      if (hold_off) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // long receiver hold-off
  initial begin
    hold_off = 0;
    wait (n_req > 200);
    @(posedge clk);
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
  end

  task automatic send(logic [3:0] o, logic [4:0] e, logic [4:0] pa, logic [3:0] q,
                      bit k, rsp_t kr);
    rsp_t x;
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1; op <= o; entry <= e; parent <= pa; queue <= q;
    do @(posedge clk); while (req_stall);
    x = pool_step(o, e, pa, q);
    pending_rsp.push_back(x);
    known_rsp.push_back(kr);
    known_flag.push_back(k);
    n_req++;
  endtask

  task automatic rand_item();
    int kind, e, pa, q;
    logic [3:0] o;
    kind = $urandom_range(99);
    e = $urandom_range(NPOOL - 1);
    pa = $urandom_range(NPOOL - 1);
    q = $urandom_range(3);
    if ($urandom_range(9) == 0) q = $urandom_range(NQ - 1);
    if (kind < 4) o = 4'($urandom_range(15, 11));
    else if (kind < 18) o = OP_ALLOC;
    else if (kind < 28) o = OP_FREE;
    else o = 4'($urandom_range(10, 2));
    if (o == OP_FREE && $urandom_range(2) != 0 && free_top != NIL) e = e;
    send(o, e[4:0], pa[4:0], q[3:0], 0, mk(0, 0, 0));
  endtask

  initial begin
    rsp_t z;
    z = mk(0, 0, 0);
    rst = 1; req_valid = 0; op = 0; entry = 0; parent = 0; queue = 0;
    send_idle = 0; recv_idle = 0; n_req = 0;
    pool_reset();
    repeat (2) @(posedge clk);
    rst <= 0;

    add_row(OP_QEMPTY, 0, 0, 15, 1, mk(ST_DONE, 0, 1));
    add_row(OP_QHEAD, 0, 0, 0, 1, mk(ST_MISS, 0, 1));
    add_row(OP_QREMOVE, 0, 0, 15, 1, mk(ST_MISS, 0, 1));
    add_row(OP_CEMPTY, 31, 0, 0, 1, mk(ST_DONE, 0, 1));
    add_row(OP_CREMOVE, 0, 0, 0, 1, mk(ST_MISS, 0, 1));
    add_row(OP_COUT, 5, 0, 0, 1, mk(ST_MISS, 0, 0));
    add_row(OP_FREE, 7, 0, 0, 1, mk(ST_DONE, 7, 0));
    add_row(OP_QINSERT, 3, 0, 0, 1, mk(ST_REFUSE, 0, 0));
    add_row(4'd11, 0, 0, 0, 1, mk(ST_REFUSE, 0, 0));
    add_row(4'd15, 31, 31, 15, 1, mk(ST_REFUSE, 0, 0));
    add_row(OP_ALLOC, 0, 0, 0, 1, mk(ST_DONE, 31, 0));
    add_row(OP_ALLOC, 0, 0, 0, 1, mk(ST_DONE, 30, 0));
    add_row(OP_CINSERT, 31, 31, 0, 1, mk(ST_REFUSE, 0, 0));
    add_row(OP_CINSERT, 0, 31, 0, 1, mk(ST_REFUSE, 0, 0));
    add_row(OP_CINSERT, 30, 31, 0, 1, mk(ST_DONE, 30, 0));
    add_row(OP_CINSERT, 30, 31, 0, 1, mk(ST_REFUSE, 0, 0));
    add_row(OP_FREE, 31, 0, 0, 1, mk(ST_REFUSE, 0, 0));
    add_row(OP_QINSERT, 31, 0, 15, 1, mk(ST_DONE, 31, 0));
    add_row(OP_QINSERT, 31, 0, 2, 1, mk(ST_REFUSE, 0, 0));
    add_row(OP_QOUT, 31, 0, 3, 1, mk(ST_MISS, 0, 0));
    add_row(OP_QHEAD, 0, 0, 15, 1, mk(ST_DONE, 31, 0));
    add_row(OP_CREMOVE, 31, 0, 0, 1, mk(ST_DONE, 30, 0));
    add_row(OP_QOUT, 31, 0, 15, 1, mk(ST_DONE, 31, 0));
    add_row(OP_FREE, 31, 0, 0, 1, mk(ST_DONE, 31, 0));
    add_row(OP_FREE, 30, 0, 0, 1, mk(ST_DONE, 30, 0));
    foreach (dir[i])
      send(dir[i].op, dir[i].entry, dir[i].parent, dir[i].queue, dir[i].known, dir[i].rsp);

    // drain the pool so alloc on empty free stack is hit
    for (int i = 0; i < NPOOL + 2; i++) send(OP_ALLOC, 0, 0, 0, 0, z);

    send_idle = 15; recv_idle = 59;
    for (int i = 0; i < 500; i++) rand_item();
    send_idle = 59; recv_idle = 15;
    for (int i = 0; i < 500; i++) rand_item();
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 450; i++) rand_item();
    req_valid <= 0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d result beats: pool, queue and child-list ops,",
             n_req, n_rsp);
    $display("misuse refusals, an exhausted pool and a long output hold-off");
    if (errors == 0) $display("PASS process_pool_list_engine");
    else $display("FAIL process_pool_list_engine");
    $finish;
  end

endmodule
